@@ rtl/core/ddn_pkg.sv @@
// ----------------------------------------------------------------------------
// ddn_pkg
// Shared types and constants for the detection decode and suppression block.
// ----------------------------------------------------------------------------
package ddn_pkg;

  localparam int DEF_MAX_BOXES   = 64;
  localparam int DEF_MAX_CLASSES = 256;
  localparam int MAX_BOXES_LIMIT = 64;
  localparam int CNT_W           = $clog2(MAX_BOXES_LIMIT + 1);
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;
  localparam int IOU_LAT         = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_PAD,
    REG_PAD_TOP,
    REG_INV_RATIO,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_SCORE_THRESHOLD,
    REG_OVERLAP_THRESHOLD
  } cfg_reg_t;

  typedef struct packed {
    logic [10:0] left_pad;
    logic [10:0] pad_top;
    logic [15:0] inv_ratio;
    logic [11:0] image_width;
    logic [11:0] image_height;
    logic [15:0] score_threshold;
    logic [15:0] overlap_threshold;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic [15:0]        box_width;
    logic [15:0]        box_height;
    logic [15:0]        class_score;
    logic               row_end;
    logic               frame_end;
  } item_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] right;
    logic [15:0] bottom;
  } box_t;

  typedef struct packed {
    box_t        box;
    logic [15:0] score;
    logic [7:0]  class_id;
    logic        sup;
  } entry_t;

  typedef struct packed {
    logic   vld;
    logic   keep;
    logic   frame;
    entry_t ent;
  } row_out_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP,
    CELL_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [CNT_W-1:0] cnt;
    entry_t           item;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_FILL,
    ST_DRAIN,
    ST_POP,
    ST_CMP,
    ST_FLUSH
  } state_t;

endpackage

@@ rtl/core/ddn_if.sv @@
// ----------------------------------------------------------------------------
// ddn_in_if / ddn_out_if
// Valid/ready channels for score words in and kept-box words out.
// ----------------------------------------------------------------------------
interface ddn_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] center_x;
  logic signed [15:0] center_y;
  logic [15:0]        box_width;
  logic [15:0]        box_height;
  logic [15:0]        class_score;
  logic               row_end;
  logic               frame_end;

  modport source (output valid, center_x, center_y, box_width, box_height, class_score,
                  row_end, frame_end, input ready);
  modport sink (input valid, center_x, center_y, box_width, box_height, class_score,
                row_end, frame_end, output ready);
endinterface

interface ddn_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] left;
  logic [15:0] top;
  logic [15:0] right;
  logic [15:0] bottom;
  logic [15:0] score;
  logic [7:0]  class_id;
  logic        last;
  logic        none_kept;
  logic        overflow;

  modport source (output valid, left, top, right, bottom, score, class_id, last, none_kept,
                  overflow, input ready);
  modport sink (input valid, left, top, right, bottom, score, class_id, last, none_kept,
                overflow, output ready);
endinterface

@@ rtl/core/ddn_row.sv @@
// ----------------------------------------------------------------------------
// ddn_row
// Per-row best class tracking and box decode: unpad, scale, corners, clip.
// ----------------------------------------------------------------------------
module ddn_row import ddn_pkg::*; #(
  parameter int MAX_CLASSES = DEF_MAX_CLASSES
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  item_t    item,
  input  cfg_t     cfg,
  output row_out_t res
);

  localparam int POS_W = $clog2(MAX_CLASSES + 1);

  logic [15:0]      best_score;
  logic [7:0]       best_class;
  logic [POS_W-1:0] class_position;
  logic             pos_open;
  logic             take_s;
  logic [15:0]      eff_score;
  logic [7:0]       eff_class;
  logic             row_done;

  assign pos_open  = class_position < POS_W'(MAX_CLASSES);
  assign take_s    = pos_open && (item.class_score > best_score);
  assign eff_score = take_s ? item.class_score : best_score;
  assign eff_class = take_s ? 8'(class_position) : best_class;
  assign row_done  = accept && (item.row_end || item.frame_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      best_score     <= '0;
      best_class     <= '0;
      class_position <= '0;
    end else if (row_done) begin
      best_score     <= '0;
      best_class     <= '0;
      class_position <= '0;
    end else if (accept) begin
      best_score <= eff_score;
      best_class <= eff_class;
      if (pos_open) class_position <= class_position + POS_W'(1);
    end
  end

  // stage a: threshold and unpad
  logic               a_vld, a_frame, a_ok;
  logic [15:0]        a_score;
  logic [7:0]         a_class;
  logic signed [17:0] a_dx, a_dy;
  logic [15:0]        a_w, a_h;

  // stage b: scale
  logic               b_vld, b_frame, b_ok;
  logic [15:0]        b_score;
  logic [7:0]         b_class;
  logic signed [34:0] b_px, b_py;
  logic [31:0]        b_pw, b_ph;

  // stage c: corners and clip
  logic               c_vld, c_frame, c_ok;
  logic [15:0]        c_score;
  logic [7:0]         c_class;
  logic signed [36:0] c_l, c_t, c_r, c_b;

  // stage d: empty check
  logic               d_vld, d_frame, d_keep;
  entry_t             d_ent;

  logic signed [36:0] sx, sy, wz, hz, lo_x, hi_x, lo_y, hi_y;
  logic signed [36:0] l_raw, r_raw, t_raw, b_raw, lim_x, lim_y;

  assign sx    = $signed({b_px[34], b_px, 1'b0});
  assign sy    = $signed({b_py[34], b_py, 1'b0});
  assign wz    = $signed({5'b0, b_pw});
  assign hz    = $signed({5'b0, b_ph});
  assign lo_x  = sx - wz;
  assign hi_x  = sx + wz;
  assign lo_y  = sy - hz;
  assign hi_y  = sy + hz;
  assign l_raw = lo_x >>> 9;
  assign r_raw = hi_x >>> 9;
  assign t_raw = lo_y >>> 9;
  assign b_raw = hi_y >>> 9;
  assign lim_x = $signed({21'b0, cfg.image_width, 4'b0});
  assign lim_y = $signed({21'b0, cfg.image_height, 4'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0; a_frame <= 1'b0;
      b_vld <= 1'b0; b_frame <= 1'b0;
      c_vld <= 1'b0; c_frame <= 1'b0;
      d_vld <= 1'b0; d_frame <= 1'b0;
    end else begin
      a_vld <= row_done;          a_frame <= row_done && item.frame_end;
      b_vld <= a_vld;             b_frame <= a_frame;
      c_vld <= b_vld;             c_frame <= b_frame;
      d_vld <= c_vld;             d_frame <= c_frame;
    end
  end

  always_ff @(posedge clk) begin
    a_ok    <= eff_score >= cfg.score_threshold;
    a_score <= eff_score;
    a_class <= eff_class;
    a_dx    <= $signed({{2{item.center_x[15]}}, item.center_x})
             - $signed({3'b0, cfg.left_pad, 4'b0});
    a_dy    <= $signed({{2{item.center_y[15]}}, item.center_y})
             - $signed({3'b0, cfg.pad_top, 4'b0});
    a_w     <= item.box_width;
    a_h     <= item.box_height;

    b_ok    <= a_ok;
    b_score <= a_score;
    b_class <= a_class;
    b_px    <= a_dx * $signed({1'b0, cfg.inv_ratio});
    b_py    <= a_dy * $signed({1'b0, cfg.inv_ratio});
    b_pw    <= a_w * cfg.inv_ratio;
    b_ph    <= a_h * cfg.inv_ratio;

    c_ok    <= b_ok;
    c_score <= b_score;
    c_class <= b_class;
    c_l     <= l_raw[36] ? '0 : l_raw;
    c_t     <= t_raw[36] ? '0 : t_raw;
    c_r     <= (r_raw > lim_x) ? lim_x : r_raw;
    c_b     <= (b_raw > lim_y) ? lim_y : b_raw;

    // a corner beyond 16 bits always fails this check, so truncation is safe
    d_keep           <= c_ok && (c_r > c_l) && (c_b > c_t);
    d_ent.box.left   <= c_l[15:0];
    d_ent.box.top    <= c_t[15:0];
    d_ent.box.right  <= c_r[15:0];
    d_ent.box.bottom <= c_b[15:0];
    d_ent.score      <= c_score;
    d_ent.class_id   <= c_class;
    d_ent.sup        <= 1'b0;
  end

  assign res.vld   = d_vld;
  assign res.frame = d_frame;
  assign res.keep  = d_keep;
  assign res.ent   = d_ent;

endmodule

@@ rtl/core/ddn_cell.sv @@
// ----------------------------------------------------------------------------
// ddn_cell
// One slot of the sorted box chain: insert by score, shift out, rotate.
// ----------------------------------------------------------------------------
module ddn_cell import ddn_pkg::*; #(
  parameter int K = 0
) (
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  entry_t    left_entry,
  input  logic      left_take,
  input  entry_t    right_entry,
  output entry_t    entry,
  output logic      take
);

  logic empty, at_tail, below_tail;

  assign empty      = CNT_W'(K) >= cmd.cnt;
  // equal scores stay ahead of the new word
  assign take       = empty || (cmd.item.score > entry.score);
  assign at_tail    = CNT_W'(K + 1) == cmd.cnt;
  assign below_tail = CNT_W'(K + 1) < cmd.cnt;

  always_ff @(posedge clk) begin
    case (cmd.op)
      CELL_INSERT: begin
        if (left_take) entry <= left_entry;
        else if (take) entry <= cmd.item;
      end
      CELL_POP: entry <= right_entry;
      CELL_ROTATE: begin
        if (at_tail) entry <= cmd.item;
        else if (below_tail) entry <= right_entry;
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/ddn_iou.sv @@
// ----------------------------------------------------------------------------
// ddn_iou
// Pipelined overlap test: inter * 2^16 > threshold * union, four stages.
// ----------------------------------------------------------------------------
module ddn_iou import ddn_pkg::*; (
  input  logic        clk,
  input  box_t        a,
  input  box_t        b,
  input  logic [15:0] thr,
  output logic        hit
);

  logic [15:0] il, it, ir, ib;
  logic [15:0] s1_iw, s1_ih, s1_wa, s1_ha, s1_wb, s1_hb;
  logic [31:0] s2_inter, s2_aa, s2_ab;
  logic [31:0] s3_inter;
  logic [32:0] s3_denom;
  logic        s3_pos;
  logic [47:0] s4_ish;
  logic [48:0] s4_prod;
  logic        s4_pos;
  logic [32:0] sum;

  assign il  = (a.left > b.left) ? a.left : b.left;
  assign it  = (a.top > b.top) ? a.top : b.top;
  assign ir  = (a.right < b.right) ? a.right : b.right;
  assign ib  = (a.bottom < b.bottom) ? a.bottom : b.bottom;
  assign sum = {1'b0, s2_aa} + {1'b0, s2_ab};

  always_ff @(posedge clk) begin
    s1_iw    <= (ir > il) ? ir - il : '0;
    s1_ih    <= (ib > it) ? ib - it : '0;
    s1_wa    <= a.right - a.left;
    s1_ha    <= a.bottom - a.top;
    s1_wb    <= b.right - b.left;
    s1_hb    <= b.bottom - b.top;

    s2_inter <= s1_iw * s1_ih;
    s2_aa    <= s1_wa * s1_ha;
    s2_ab    <= s1_wb * s1_hb;

    s3_inter <= s2_inter;
    s3_pos   <= sum > {1'b0, s2_inter};
    s3_denom <= sum - {1'b0, s2_inter};

    s4_ish   <= {s3_inter, 16'b0};
    s4_prod  <= thr * s3_denom;
    s4_pos   <= s3_pos;
  end

  assign hit = s4_pos && ({1'b0, s4_ish} > s4_prod);

endmodule

@@ rtl/core/detection_decode_nms.sv @@
// ----------------------------------------------------------------------------
// detection_decode_nms
// Box decode from class scores, sorted box chain and greedy suppression.
// ----------------------------------------------------------------------------
// Scores: one word a cycle within a frame; a row's box passes decode stages a, b, c and d before it reaches the chain.
// Frame end: input held off while the decode stages drain, then each stored box is popped in turn;
//   each kept box is compared with every remaining box through the shared overlap pipeline,
//   which marks the ones it suppresses, and the frame then closes with a last word.
// Results leave through an output register; a full register stalls the suppression walk.
// Reset (rst, synchronous) loads the register defaults and empties the chain; no clearing pass.
module detection_decode_nms import ddn_pkg::*; #(
  parameter int MAX_BOXES   = DEF_MAX_BOXES,
  parameter int MAX_CLASSES = DEF_MAX_CLASSES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ddn_in_if.sink                det_in,
  ddn_out_if.source             det_out
);

  localparam int W_W = $clog2(IOU_LAT + 1);

  cfg_t             cfg;
  item_t            item;
  row_out_t         row_res;
  cell_cmd_t        cmd;
  entry_t           ent [MAX_BOXES];
  logic             tk  [MAX_BOXES];
  entry_t           head;
  entry_t           cand;
  logic             cand_vld;
  logic             hit;
  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, rot_left;
  logic [W_W-1:0]   wcnt;
  logic             ovf;
  logic             in_acc, in_ready, out_free;
  logic             do_pop, do_keep, do_rot, ins, ovf_set;
  logic             push, push_last, push_none;

  logic        out_vld, out_last, out_none, out_ovf;
  entry_t      out_ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_pad          <= '0;
      cfg.pad_top           <= '0;
      cfg.inv_ratio         <= 16'd256;
      cfg.image_width       <= 12'd640;
      cfg.image_height      <= 12'd640;
      cfg.score_threshold   <= 16'd22938;
      cfg.overlap_threshold <= 16'd29491;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LEFT_PAD:          cfg.left_pad          <= cfg_data[10:0];
        REG_PAD_TOP:           cfg.pad_top           <= cfg_data[10:0];
        REG_INV_RATIO:         cfg.inv_ratio         <= cfg_data;
        REG_IMAGE_WIDTH:       cfg.image_width       <= cfg_data[11:0];
        REG_IMAGE_HEIGHT:      cfg.image_height      <= cfg_data[11:0];
        REG_SCORE_THRESHOLD:   cfg.score_threshold   <= cfg_data;
        REG_OVERLAP_THRESHOLD: cfg.overlap_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  assign item.center_x    = det_in.center_x;
  assign item.center_y    = det_in.center_y;
  assign item.box_width   = det_in.box_width;
  assign item.box_height  = det_in.box_height;
  assign item.class_score = det_in.class_score;
  assign item.row_end     = det_in.row_end;
  assign item.frame_end   = det_in.frame_end;
  assign det_in.ready     = in_ready;
  assign in_acc           = det_in.valid && in_ready;

  ddn_row #(.MAX_CLASSES(MAX_CLASSES)) u_row (
    .clk    (clk),
    .rst    (rst),
    .accept (in_acc),
    .item   (item),
    .cfg    (cfg),
    .res    (row_res)
  );

  for (genvar k = 0; k < MAX_BOXES; k++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_t;
    if (k == 0) begin : g_first
      assign left_e = cmd.item;
      assign left_t = 1'b0;
    end else begin : g_mid
      assign left_e = ent[k-1];
      assign left_t = tk[k-1];
    end
    if (k == MAX_BOXES - 1) begin : g_end
      assign right_e = ent[k];
    end else begin : g_inner
      assign right_e = ent[k+1];
    end
    ddn_cell #(.K(k)) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .left_entry  (left_e),
      .left_take   (left_t),
      .right_entry (right_e),
      .entry       (ent[k]),
      .take        (tk[k])
    );
  end

  assign head = ent[0];

  ddn_iou u_iou (
    .clk (clk),
    .a   (cand.box),
    .b   (head.box),
    .thr (cfg.overlap_threshold),
    .hit (hit)
  );

  assign out_free = !out_vld || det_out.ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_FILL:  if (in_acc && item.frame_end) state_next = ST_DRAIN;
      ST_DRAIN: if (row_res.vld && row_res.frame) state_next = ST_POP;
      ST_POP: begin
        if (cnt == '0) state_next = ST_FLUSH;
        else if (do_keep && cnt != CNT_W'(1)) state_next = ST_CMP;
      end
      ST_CMP:   if (do_rot && rot_left == CNT_W'(1)) state_next = ST_POP;
      ST_FLUSH: if (out_free) state_next = ST_FILL;
      default:  state_next = ST_FILL;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd.op    = CELL_HOLD;
    cmd.cnt   = cnt;
    cmd.item  = row_res.ent;
    do_pop    = 1'b0;
    do_keep   = 1'b0;
    do_rot    = 1'b0;
    ins       = 1'b0;
    ovf_set   = 1'b0;
    push      = 1'b0;
    push_last = 1'b0;
    push_none = 1'b0;
    if (row_res.vld && row_res.keep) begin
      if (cnt == CNT_W'(MAX_BOXES)) begin
        ovf_set = 1'b1;
      end else begin
        ins    = 1'b1;
        cmd.op = CELL_INSERT;
      end
    end
    case (state)
      ST_FILL: in_ready = 1'b1;
      ST_POP: begin
        if (cnt != '0) begin
          if (head.sup) begin
            do_pop = 1'b1;
          end else if (!cand_vld || out_free) begin
            // release the previous kept word, hold this one until its suppressions end
            do_pop  = 1'b1;
            do_keep = 1'b1;
            push    = cand_vld;
          end
        end
      end
      ST_CMP: begin
        if (wcnt == W_W'(IOU_LAT)) begin
          do_rot       = 1'b1;
          cmd.op       = CELL_ROTATE;
          cmd.item     = head;
          cmd.item.sup = head.sup || hit;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          push_none = !cand_vld;
        end
      end
      default: ;
    endcase
    if (do_pop) cmd.op = CELL_POP;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_FILL;
      cnt      <= '0;
      rot_left <= '0;
      wcnt     <= '0;
      cand_vld <= 1'b0;
      ovf      <= 1'b0;
      out_vld  <= 1'b0;
    end else begin
      state <= state_next;
      if (ins) cnt <= cnt + CNT_W'(1);
      else if (do_pop) cnt <= cnt - CNT_W'(1);
      if (do_keep) rot_left <= cnt - CNT_W'(1);
      else if (do_rot) rot_left <= rot_left - CNT_W'(1);
      if (do_keep || do_rot) wcnt <= '0;
      else if (state == ST_CMP) wcnt <= wcnt + W_W'(1);
      if (do_keep) cand_vld <= 1'b1;
      else if (push && push_last) cand_vld <= 1'b0;
      if (ovf_set) ovf <= 1'b1;
      else if (push && push_last) ovf <= 1'b0;
      if (push) out_vld <= 1'b1;
      else if (det_out.ready) out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_keep) cand <= head;
    if (push) begin
      out_ent  <= push_none ? '0 : cand;
      out_last <= push_last;
      out_none <= push_none;
      out_ovf  <= ovf;
    end
  end

  assign det_out.valid     = out_vld;
  assign det_out.left      = out_ent.box.left;
  assign det_out.top       = out_ent.box.top;
  assign det_out.right     = out_ent.box.right;
  assign det_out.bottom    = out_ent.box.bottom;
  assign det_out.score     = out_ent.score;
  assign det_out.class_id  = out_ent.class_id;
  assign det_out.last      = out_last;
  assign det_out.none_kept = out_none;
  assign det_out.overflow  = out_ovf;

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    (ovf && (state == ST_FILL || state == ST_DRAIN)) |-> cnt == CNT_W'(MAX_BOXES))
    else $error("overflow flagged with room left in the chain");

  a_rot_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CMP) |-> rot_left != '0)
    else $error("compare phase with no boxes left to rotate");

  a_flush_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH && out_free) |=> (state == ST_FILL && out_vld && out_last))
    else $error("frame close did not leave a last word");

  a_no_input_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_FILL) |-> !in_acc)
    else $error("score word taken while the frame is being sorted");

endmodule
